FILE: hdl/prl_pkg.sv
// shared types and codes for the priority ready list table
package prl_pkg;

	// widest slot memory address (LEVELS * SLOTS up to 1024 entries)
	localparam int MEM_AW = 10;
	localparam int ID_W   = 8;

	// request codes
	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_MISS  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic            req_type;
		logic [3:0]      priority_req;
		logic [ID_W-1:0] thread_id;
	} prl_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] level_count;
	} prl_rsp_t;

	// slot memory access from the sequencer
	typedef struct packed {
		logic              wr_en;
		logic [MEM_AW-1:0] wr_addr;
		logic [ID_W-1:0]   wr_data;
		logic [MEM_AW-1:0] rd_addr;
	} prl_mem_req_t;

endpackage

FILE: hdl/priority_ready_list_table.sv
// priority ready list table: per-level ordered thread lists with add and remove
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | prl_req_t (req_type, priority_req, thread_id)
//   rsp     | out       | rsp_valid/rsp_stall | prl_rsp_t (status, level_count)
//
// one item at a time: an add goes from accept through the lookup to the result, a
// remove scans the level entry by entry and then closes the gap, a rejected
// priority goes straight to the result. the scan and the gap close both go
// through the single read port of the slot memory, address then registered data.
// reset clears the level counts and sequencer, not the slot memory; slot contents are never read unwritten.
// a stalled result holds in the output register while the next item is taken.
module priority_ready_list_table
	import prl_pkg::*;
#(
	parameter int SLOTS  = 16,
	parameter int LEVELS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  prl_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output prl_rsp_t rsp
);

	localparam int CW    = $clog2(SLOTS + 1);
	localparam int CXW   = (CW > 5) ? CW : 5;
	localparam int LVW   = $clog2(LEVELS);
	localparam int DEPTH = LEVELS * SLOTS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SH_RD,
		S_SH_WR,
		S_DONE
	} state_t;

	state_t          state_q;
	logic            op_q;
	logic [3:0]      lvl_q;
	logic [ID_W-1:0] id_q;
	logic [CW-1:0]   cnt_q [LEVELS];
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   idx_q;
	logic [AW-1:0]   base_q;
	logic [1:0]      st_q;
	logic [CW-1:0]   res_cnt_q;
	logic            rsp_valid_q;
	prl_rsp_t        rsp_q;

	logic [LVW-1:0]  lvl_i;
	logic [CW-1:0]   n_c;
	logic [AW-1:0]   base_c;
	logic [CXW-1:0]  res_cnt_x;
	logic            in_range;
	prl_mem_req_t    mem_req;
	logic [ID_W-1:0] rd_data;

	prl_slot_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk    (clk),
		.mem_req(mem_req),
		.rd_data(rd_data)
	);

	// level lookup
	assign lvl_i     = lvl_q[LVW-1:0];
	assign n_c       = cnt_q[lvl_i];
	assign base_c    = AW'(lvl_i) * AW'(SLOTS);
	assign in_range  = 5'(req.priority_req) < 5'(LEVELS);
	assign res_cnt_x = CXW'(res_cnt_q);

	// slot memory addressing
	always_comb begin
		mem_req         = '0;
		mem_req.wr_data = id_q;
		case (state_q)
			S_LOOK: begin
				mem_req.wr_en   = (op_q == REQ_ADD) && (n_c != CW'(SLOTS));
				mem_req.wr_addr = MEM_AW'(base_c + AW'(n_c));
			end
			S_SCAN_RD: begin
				mem_req.rd_addr = MEM_AW'(base_q + AW'(idx_q));
			end
			S_SH_RD: begin
				mem_req.rd_addr = MEM_AW'(base_q + AW'(idx_q + CW'(1)));
			end
			S_SH_WR: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = MEM_AW'(base_q + AW'(idx_q));
				mem_req.wr_data = rd_data;
			end
			default: begin
				mem_req.wr_en = 1'b0;
			end
		endcase
	end

	// sequencer, level counts and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= REQ_ADD;
			lvl_q       <= '0;
			id_q        <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			base_q      <= '0;
			st_q        <= ST_OK;
			res_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			for (int k = 0; k < LEVELS; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			// result taken and no new one loading this cycle
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q  <= req.req_type;
						lvl_q <= req.priority_req;
						id_q  <= req.thread_id;
						if (in_range) begin
							state_q <= S_LOOK;
						end else begin
							st_q      <= ST_RANGE;
							res_cnt_q <= '0;
							state_q   <= S_DONE;
						end
					end
				end
				S_LOOK: begin
					n_q    <= n_c;
					base_q <= base_c;
					idx_q  <= '0;
					if (op_q == REQ_ADD) begin
						if (n_c == CW'(SLOTS)) begin
							st_q      <= ST_FULL;
							res_cnt_q <= n_c;
						end else begin
							cnt_q[lvl_i] <= n_c + CW'(1);
							st_q         <= ST_OK;
							res_cnt_q    <= n_c + CW'(1);
						end
						state_q <= S_DONE;
					end else if (n_c == '0) begin
						st_q      <= ST_MISS;
						res_cnt_q <= '0;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CMP;
				end
				// compare one entry against the identifier
				S_SCAN_CMP: begin
					if (rd_data == id_q) begin
						if (idx_q + CW'(1) == n_q) begin
							cnt_q[lvl_i] <= n_q - CW'(1);
							st_q         <= ST_OK;
							res_cnt_q    <= n_q - CW'(1);
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SH_RD;
						end
					end else if (idx_q + CW'(1) == n_q) begin
						st_q      <= ST_MISS;
						res_cnt_q <= n_q;
						state_q   <= S_DONE;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				// move the next entry down one place
				S_SH_WR: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q + CW'(2) == n_q) begin
						cnt_q[lvl_i] <= n_q - CW'(1);
						st_q         <= ST_OK;
						res_cnt_q    <= n_q - CW'(1);
						state_q      <= S_DONE;
					end else begin
						state_q <= S_SH_RD;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.status      <= st_q;
						rsp_q.level_count <= res_cnt_x[4:0];
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

FILE: hdl/prl_slot_mem.sv
// slot memory: one write port, one read port with registered read data
module prl_slot_mem
	import prl_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  logic            clk,
	input  prl_mem_req_t    mem_req,
	output logic [ID_W-1:0] rd_data
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [ID_W-1:0] mem_q [DEPTH];
	logic [ID_W-1:0] rd_data_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			mem_q[mem_req.wr_addr[IW-1:0]] <= mem_req.wr_data;
		end
		rd_data_q <= mem_q[mem_req.rd_addr[IW-1:0]];
	end

	assign rd_data = rd_data_q;

endmodule
